@@ rtl/core/lru_block_cache_directory_core_defines.svh @@
// ---------------------------------------------------------------------------
// LRU block cache directory assertion macros
// Shared concurrent check helpers, clocked on clk, off during arst_n.
// ---------------------------------------------------------------------------
`ifndef LRU_BLOCK_CACHE_DIRECTORY_CORE_DEFINES_SVH
`define LRU_BLOCK_CACHE_DIRECTORY_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LBCD_ASSERT_IMPLIES(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("same-cycle check failed");
`define LBCD_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");
`else
`define LBCD_ASSERT_IMPLIES(lbl, a, b)
`define LBCD_ASSERT_NEXT(lbl, a, b)
`endif
`endif

@@ rtl/core/lbcd_pkg.sv @@
// ---------------------------------------------------------------------------
// LRU block cache directory package
// Entry layout, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package lbcd_pkg;

	localparam int TAG_W   = 63;
	localparam int STAMP_W = 64;
	localparam int SLOT_W  = 6;
	localparam int ACT_W   = 2;

	// recency stamps start mid-range so both ends can grow
	localparam logic [STAMP_W-1:0] STAMP_BASE = {1'b1, {(STAMP_W-1){1'b0}}};

	localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_NONE  = 2'd2;

	localparam logic OP_READ = 1'b0;

	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic clr_we;   // clearing pass write
		logic load_in;  // capture input beat
		logic rd_en;    // scan read
		logic commit;   // update entry and load result
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

@@ rtl/core/lru_block_cache_directory_core.sv @@
// ---------------------------------------------------------------------------
// LRU block cache directory core
// Fully associative write-through block cache directory with LRU victims.
// ---------------------------------------------------------------------------
// Each input beat is one block reference. The directory is scanned one slot
// a cycle through the registered read port of the entry memory, and a beat
// goes through the scan, the last-read state and the commit before the next
// beat is taken; the scan loop over the memory read port sets the pace. A
// previous result still stalled on the output holds the commit, and so the next
// acceptance, until it leaves. Recency is kept as a per-slot stamp: the lowest
// stamp is the next victim, a touched slot gets a new highest stamp, or under
// bypass a new lowest one. After reset a clearing pass over every slot
// initializes the memory; input stays stalled then, while configuration writes
// are taken. The result sits in an output register, so a finished result may
// wait while the next beat is accepted.
// ---------------------------------------------------------------------------
module lru_block_cache_directory_core #(
	parameter int NUM_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        nocache_mode,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [62:0] block_number,
	input  logic        bypass_request,
	input  logic        last_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [5:0]  slot,
	output logic [1:0]  action,
	output logic        evicted_valid,
	output logic [62:0] evicted_block,
	output logic        last_out
);
	import lbcd_pkg::*;

	localparam int AW = $clog2(NUM_SLOTS);

	cmd_t          cmd;
	status_t       status;
	logic [AW-1:0] addr;

	// the register is always writable
	assign cfg_ready = 1'b1;

	lbcd_ctrl #(.NUM_SLOTS(NUM_SLOTS), .AW(AW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd),
		.addr     (addr)
	);

	lbcd_datapath #(.NUM_SLOTS(NUM_SLOTS), .AW(AW)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.addr           (addr),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.nocache_mode   (nocache_mode),
		.opcode         (opcode),
		.block_number   (block_number),
		.bypass_request (bypass_request),
		.last_block     (last_block),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.slot           (slot),
		.action         (action),
		.evicted_valid  (evicted_valid),
		.evicted_block  (evicted_block),
		.last_out       (last_out)
	);

endmodule

@@ rtl/core/lbcd_ctrl.sv @@
// ---------------------------------------------------------------------------
// LRU block cache directory controller
// Sequences the clearing pass, the directory scan and the commit.
// ---------------------------------------------------------------------------
module lbcd_ctrl #(
	parameter int NUM_SLOTS = 64,
	parameter int AW = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lbcd_pkg::status_t  status,
	output lbcd_pkg::cmd_t     cmd,
	output logic [AW-1:0]      addr
);
	import lbcd_pkg::*;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_LAST, S_COMMIT} state_t;

	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SLOTS - 1);

	state_t        state_q;
	logic [AW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) state_q <= S_IDLE;
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) state_q <= S_LAST;
				end
				S_LAST: state_q <= S_COMMIT;
				S_COMMIT: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_comb begin
		in_stall    = (state_q != S_IDLE);
		cmd.clr_we  = (state_q == S_CLEAR);
		cmd.load_in = (state_q == S_IDLE) && in_valid;
		cmd.rd_en   = (state_q == S_SCAN);
		cmd.commit  = (state_q == S_COMMIT) && status.out_free;
		addr        = cnt_q;
	end

endmodule

@@ rtl/core/lbcd_datapath.sv @@
// ---------------------------------------------------------------------------
// LRU block cache directory datapath
// Entry memory, scan trackers, recency stamps and result register.
// ---------------------------------------------------------------------------
`include "lru_block_cache_directory_core_defines.svh"
module lbcd_datapath #(
	parameter int NUM_SLOTS = 64,
	parameter int AW = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lbcd_pkg::cmd_t            cmd,
	input  logic [AW-1:0]             addr,
	output lbcd_pkg::status_t         status,
	input  logic                      cfg_valid,
	input  logic                      nocache_mode,
	input  logic                      opcode,
	input  logic [lbcd_pkg::TAG_W-1:0] block_number,
	input  logic                      bypass_request,
	input  logic                      last_block,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      hit,
	output logic [lbcd_pkg::SLOT_W-1:0] slot,
	output logic [lbcd_pkg::ACT_W-1:0]  action,
	output logic                      evicted_valid,
	output logic [lbcd_pkg::TAG_W-1:0] evicted_block,
	output logic                      last_out
);
	import lbcd_pkg::*;

	localparam logic [STAMP_W-1:0] STAMP_TOP = STAMP_BASE + STAMP_W'(NUM_SLOTS - 1);

	entry_t mem [NUM_SLOTS];
	entry_t rd_q;
	logic   rdv_q;
	logic [AW-1:0] ridx_q;

	logic nocache_q;
	logic op_q, byp_q, last_q;
	logic [TAG_W-1:0] bn_q;

	logic found_q;
	logic [AW-1:0] hidx_q, vidx_q;
	logic [STAMP_W-1:0] min_q;
	logic vvalid_q;
	logic [TAG_W-1:0] vtag_q;

	logic [STAMP_W-1:0] lo_q, hi_q;
	logic miss_q;

	logic out_valid_q, hit_q, evv_q, lastout_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ACT_W-1:0] act_q;
	logic [TAG_W-1:0] evb_q;

	logic touched, alloc, mem_we;
	logic [AW-1:0] s, waddr;
	logic [STAMP_W-1:0] new_stamp;
	entry_t wdata;
	logic [ACT_W-1:0] act_d;

	assign status.out_free = !out_valid_q || !out_stall;

	always_comb begin
		alloc     = !found_q && !byp_q;
		touched   = found_q || !byp_q;
		s         = found_q ? hidx_q : vidx_q;
		new_stamp = byp_q ? lo_q - 1'b1 : hi_q + 1'b1;
		if (found_q) begin
			if (op_q != OP_READ) act_d = ACT_WRITE;
			else if (miss_q)     act_d = ACT_NONE;
			else                 act_d = ACT_READ;
		end else begin
			act_d = alloc ? ACT_WRITE : ACT_NONE;
		end
		if (cmd.clr_we) begin
			mem_we      = 1'b1;
			waddr       = addr;
			wdata.valid = 1'b0;
			wdata.tag   = '0;
			wdata.stamp = STAMP_BASE + STAMP_W'(addr);
		end else begin
			mem_we      = cmd.commit && touched;
			waddr       = s;
			wdata.valid = 1'b1;
			wdata.tag   = bn_q;
			wdata.stamp = new_stamp;
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (cmd.rd_en) rd_q <= mem[addr];
		ridx_q <= addr;
	end

	// payload captures and scan trackers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= opcode;
			bn_q    <= block_number;
			byp_q   <= bypass_request || nocache_q;
			last_q  <= last_block;
			found_q <= 1'b0;
			hidx_q  <= '0;
		end else if (rdv_q) begin
			if (rd_q.valid && rd_q.tag == bn_q && !found_q) begin
				found_q <= 1'b1;
				hidx_q  <= ridx_q;
			end
			// lowest stamp is the next victim
			if (ridx_q == '0 || rd_q.stamp < min_q) begin
				min_q    <= rd_q.stamp;
				vidx_q   <= ridx_q;
				vvalid_q <= rd_q.valid;
				vtag_q   <= rd_q.tag;
			end
		end
		if (cmd.commit) begin
			hit_q     <= found_q;
			slot_q    <= touched ? SLOT_W'(s) : '0;
			act_q     <= act_d;
			evv_q     <= alloc && vvalid_q;
			evb_q     <= (alloc && vvalid_q) ? vtag_q : '0;
			lastout_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_q       <= 1'b0;
			nocache_q   <= 1'b0;
			lo_q        <= STAMP_BASE;
			hi_q        <= STAMP_TOP;
			miss_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_q <= cmd.rd_en;
			if (cfg_valid) nocache_q <= nocache_mode;
			if (cmd.commit) begin
				if (touched && byp_q)  lo_q <= new_stamp;
				if (touched && !byp_q) hi_q <= new_stamp;
				if (last_q)                           miss_q <= 1'b0;
				else if (!found_q && op_q == OP_READ) miss_q <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign action        = act_q;
	assign evicted_valid = evv_q;
	assign evicted_block = evb_q;
	assign last_out      = lastout_q;

	`LBCD_ASSERT_IMPLIES(a_commit_free, cmd.commit, status.out_free)
	`LBCD_ASSERT_IMPLIES(a_no_scan_at_commit, cmd.commit, !rdv_q && !cmd.rd_en)
	`LBCD_ASSERT_NEXT(a_result_held, out_valid_q && out_stall, out_valid_q && $stable(act_q))

endmodule
